>>> design/lact_pkg.sv
// Shared types and constants for the lock and condition table core.
// No dependencies; imported by lock_and_condition_table_core.
package lact_pkg;

  // Default table sizes
  localparam int LOCK_COUNT_DEF = 32;
  localparam int COND_COUNT_DEF = 32;

  // Saturation limits of the counters
  localparam logic [15:0] NEST_MAX = 16'hFFFF;
  localparam logic [6:0]  WAIT_MAX = 7'd127;

  typedef enum logic [3:0] {
    CMD_LOCK_CREATE  = 4'd0,
    CMD_LOCK_DESTROY = 4'd1,
    CMD_ACQUIRE      = 4'd2,
    CMD_RESUME       = 4'd3,
    CMD_RELEASE      = 4'd4,
    CMD_COND_CREATE  = 4'd5,
    CMD_COND_DESTROY = 4'd6,
    CMD_WAIT         = 4'd7,
    CMD_SIGNAL       = 4'd8,
    CMD_BROADCAST    = 4'd9
  } cmd_code_t;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_NESTED   = 3'd1,
    ST_WAIT     = 3'd2,
    ST_FULL     = 3'd3,
    ST_BUSY     = 3'd4,
    ST_NOTOWNER = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    MODE_FREE     = 2'd0,
    MODE_HELD     = 2'd1,
    MODE_RESERVED = 2'd2
  } lock_mode_t;

  typedef struct packed {
    cmd_code_t   command;
    logic [4:0]  lock_index;
    logic [4:0]  cond_index;
    logic [5:0]  thread_id;
  } cmd_word_t;

  typedef struct packed {
    status_t     status;
    logic [4:0]  new_index;
    logic        wake_lock_waiter;
    logic [6:0]  cond_wake_count;
  } rsp_word_t;

endpackage

>>> design/lock_and_condition_table_core.sv
// Lock and condition-variable table manager, top level.
// Depends on lact_pkg for word types, command, status and mode codes.
//
// Serves one command word per cycle while the consumer does not stall, and
// returns exactly one response word for each. A command is captured in an
// input register; once the response register can take a word, single-pass
// logic reads the addressed lock and condition entries (plus a priority
// encoder over the in-use bits for creates), updates them and loads the
// response register. cmd_stall rises only while the response register holds
// a word the consumer is stalling. Of the table state, only the in-use bits
// are cleared by reset; an entry's other fields are written when it is
// created, so no clearing pass is needed.
// Wakeups are reported, not scheduled: software keeps the sleeping threads.
module lock_and_condition_table_core
  import lact_pkg::*;
#(
  parameter int LOCK_COUNT = LOCK_COUNT_DEF,
  parameter int COND_COUNT = COND_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  cmd_word_t cmd,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_word_t rsp
);

  localparam int LIW = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;
  localparam int CIW = (COND_COUNT > 1) ? $clog2(COND_COUNT) : 1;

  // Table storage
  logic              lock_in_use  [LOCK_COUNT];
  lock_mode_t        lock_mode    [LOCK_COUNT];
  logic [5:0]        lock_owner   [LOCK_COUNT];
  logic [15:0]       lock_nesting [LOCK_COUNT];
  logic [6:0]        lock_waiters [LOCK_COUNT];
  logic              cond_in_use  [COND_COUNT];
  logic [6:0]        cond_waiters [COND_COUNT];

  // Input register
  logic      in_full;
  cmd_word_t in_word;
  logic      advance;

  // Decoded access
  logic [8:0]      lidx_wide, cidx_wide;
  logic [LIW-1:0]  lsel;
  logic [CIW-1:0]  csel;
  logic            lock_ok, cond_ok;
  lock_mode_t      cur_mode;
  logic [5:0]      cur_owner;
  logic [15:0]     cur_nest;
  logic [6:0]      cur_wait, cur_cwait;
  logic            owner_ok;

  // Free-entry search
  logic            lock_free_found, cond_free_found;
  logic [LIW-1:0]  lock_free;
  logic [CIW-1:0]  cond_free;

  // Release step
  lock_mode_t      rel_mode;
  logic [5:0]      rel_owner;
  logic [15:0]     rel_nest;
  logic            rel_wake;

  // Update controls
  logic            lk_we, lk_use_we, lk_use_val, lk_alloc;
  lock_mode_t      lk_mode_next;
  logic [5:0]      lk_owner_next;
  logic [15:0]     lk_nest_next;
  logic [6:0]      lk_wait_next;
  logic            cd_we, cd_use_clr, cd_alloc;
  logic [6:0]      cd_wait_next;
  rsp_word_t       rsp_next;

  // Handshake: the pass fires when the response register can take a word
  assign advance   = in_full && (!rsp_valid || !rsp_stall);
  assign cmd_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (cmd_valid && !cmd_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      in_word <= cmd;
    end
  end

  // Entry selection and bounds check
  assign lidx_wide = {4'b0, in_word.lock_index};
  assign cidx_wide = {4'b0, in_word.cond_index};
  assign lsel      = lidx_wide[LIW-1:0];
  assign csel      = cidx_wide[CIW-1:0];
  assign lock_ok   = (lidx_wide < 9'(LOCK_COUNT)) && lock_in_use[lsel];
  assign cond_ok   = (cidx_wide < 9'(COND_COUNT)) && cond_in_use[csel];
  assign cur_mode  = lock_mode[lsel];
  assign cur_owner = lock_owner[lsel];
  assign cur_nest  = lock_nesting[lsel];
  assign cur_wait  = lock_waiters[lsel];
  assign cur_cwait = cond_waiters[csel];
  assign owner_ok  = (cur_mode == MODE_HELD) && (cur_owner == in_word.thread_id);

  // First free entry, lowest index wins
  always_comb begin
    lock_free_found = 1'b0;
    lock_free       = '0;
    for (int i = LOCK_COUNT - 1; i >= 0; i--) begin
      if (!lock_in_use[i]) begin
        lock_free_found = 1'b1;
        lock_free       = LIW'(i);
      end
    end
  end

  always_comb begin
    cond_free_found = 1'b0;
    cond_free       = '0;
    for (int i = COND_COUNT - 1; i >= 0; i--) begin
      if (!cond_in_use[i]) begin
        cond_free_found = 1'b1;
        cond_free       = CIW'(i);
      end
    end
  end

  // One release step: nest down, or free / reserve for a waiter
  always_comb begin
    rel_wake  = 1'b0;
    rel_mode  = cur_mode;
    rel_owner = cur_owner;
    rel_nest  = cur_nest;
    if (cur_nest > 16'd1) begin
      rel_nest = cur_nest - 16'd1;
    end else begin
      rel_nest  = '0;
      rel_owner = '0;
      if (cur_wait != '0) begin
        rel_mode = MODE_RESERVED;
        rel_wake = 1'b1;
      end else begin
        rel_mode = MODE_FREE;
      end
    end
  end

  // Command decode
  always_comb begin
    lk_we         = 1'b0;
    lk_use_we     = 1'b0;
    lk_use_val    = 1'b0;
    lk_alloc      = 1'b0;
    lk_mode_next  = cur_mode;
    lk_owner_next = cur_owner;
    lk_nest_next  = cur_nest;
    lk_wait_next  = cur_wait;
    cd_we         = 1'b0;
    cd_use_clr    = 1'b0;
    cd_alloc      = 1'b0;
    cd_wait_next  = cur_cwait;
    rsp_next      = '{status: ST_BUSY, new_index: '0, wake_lock_waiter: 1'b0,
                      cond_wake_count: '0};
    case (in_word.command)
      CMD_LOCK_CREATE: begin
        if (lock_free_found) begin
          lk_alloc           = 1'b1;
          rsp_next.status    = ST_DONE;
          rsp_next.new_index = 5'(lock_free);
        end else begin
          rsp_next.status = ST_FULL;
        end
      end
      CMD_LOCK_DESTROY: begin
        if (lock_ok && cur_mode == MODE_FREE && cur_wait == '0) begin
          lk_use_we       = 1'b1;
          lk_use_val      = 1'b0;
          rsp_next.status = ST_DONE;
        end
      end
      CMD_ACQUIRE: begin
        if (lock_ok) begin
          lk_we = 1'b1;
          if (cur_mode == MODE_FREE) begin
            lk_mode_next    = MODE_HELD;
            lk_owner_next   = in_word.thread_id;
            lk_nest_next    = 16'd1;
            rsp_next.status = ST_DONE;
          end else if (owner_ok) begin
            if (cur_nest < NEST_MAX) begin
              lk_nest_next = cur_nest + 16'd1;
            end
            rsp_next.status = ST_NESTED;
          end else begin
            if (cur_wait < WAIT_MAX) begin
              lk_wait_next = cur_wait + 7'd1;
            end
            rsp_next.status = ST_WAIT;
          end
        end
      end
      CMD_RESUME: begin
        if (lock_ok && cur_mode == MODE_RESERVED) begin
          lk_we = 1'b1;
          if (cur_wait != '0) begin
            lk_wait_next = cur_wait - 7'd1;
          end
          lk_mode_next    = MODE_HELD;
          lk_owner_next   = in_word.thread_id;
          lk_nest_next    = 16'd1;
          rsp_next.status = ST_DONE;
        end
      end
      CMD_RELEASE: begin
        if (lock_ok) begin
          if (!owner_ok) begin
            rsp_next.status = ST_NOTOWNER;
          end else begin
            lk_we                     = 1'b1;
            lk_mode_next              = rel_mode;
            lk_owner_next             = rel_owner;
            lk_nest_next              = rel_nest;
            rsp_next.wake_lock_waiter = rel_wake;
            rsp_next.status           = ST_DONE;
          end
        end
      end
      CMD_COND_CREATE: begin
        if (cond_free_found) begin
          cd_alloc           = 1'b1;
          rsp_next.status    = ST_DONE;
          rsp_next.new_index = 5'(cond_free);
        end else begin
          rsp_next.status = ST_FULL;
        end
      end
      CMD_COND_DESTROY: begin
        if (cond_ok && cur_cwait == '0) begin
          cd_use_clr      = 1'b1;
          rsp_next.status = ST_DONE;
        end
      end
      CMD_WAIT: begin
        if (cond_ok && lock_ok) begin
          if (!owner_ok) begin
            rsp_next.status = ST_NOTOWNER;
          end else begin
            cd_we = 1'b1;
            if (cur_cwait < WAIT_MAX) begin
              cd_wait_next = cur_cwait + 7'd1;
            end
            lk_we                     = 1'b1;
            lk_mode_next              = rel_mode;
            lk_owner_next             = rel_owner;
            lk_nest_next              = rel_nest;
            rsp_next.wake_lock_waiter = rel_wake;
            rsp_next.status           = ST_DONE;
          end
        end
      end
      CMD_SIGNAL: begin
        if (cond_ok) begin
          if (cur_cwait != '0) begin
            cd_we                    = 1'b1;
            cd_wait_next             = cur_cwait - 7'd1;
            rsp_next.cond_wake_count = 7'd1;
          end
          rsp_next.status = ST_DONE;
        end
      end
      CMD_BROADCAST: begin
        if (cond_ok) begin
          cd_we                    = 1'b1;
          cd_wait_next             = '0;
          rsp_next.cond_wake_count = cur_cwait;
          rsp_next.status          = ST_DONE;
        end
      end
      default: begin
        rsp_next.status = ST_BUSY;
      end
    endcase
  end

  // Lock table in-use bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LOCK_COUNT; i++) begin
        lock_in_use[i] <= 1'b0;
      end
    end else if (advance) begin
      if (lk_alloc) begin
        lock_in_use[lock_free] <= 1'b1;
      end else if (lk_use_we) begin
        lock_in_use[lsel] <= lk_use_val;
      end
    end
  end

  // Lock table fields
  always_ff @(posedge clk) begin
    if (advance) begin
      if (lk_alloc) begin
        lock_mode[lock_free]    <= MODE_FREE;
        lock_owner[lock_free]   <= '0;
        lock_nesting[lock_free] <= '0;
        lock_waiters[lock_free] <= '0;
      end else if (lk_we) begin
        lock_mode[lsel]    <= lk_mode_next;
        lock_owner[lsel]   <= lk_owner_next;
        lock_nesting[lsel] <= lk_nest_next;
        lock_waiters[lsel] <= lk_wait_next;
      end
    end
  end

  // Condition table in-use bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < COND_COUNT; i++) begin
        cond_in_use[i] <= 1'b0;
      end
    end else if (advance) begin
      if (cd_alloc) begin
        cond_in_use[cond_free] <= 1'b1;
      end else if (cd_use_clr) begin
        cond_in_use[csel] <= 1'b0;
      end
    end
  end

  // Condition waiter counts
  always_ff @(posedge clk) begin
    if (advance) begin
      if (cd_alloc) begin
        cond_waiters[cond_free] <= '0;
      end else if (cd_we) begin
        cond_waiters[csel] <= cd_wait_next;
      end
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= rsp_next;
    end
  end

  // Checks
  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> (rsp_valid && rsp_stall))
    else $error("command stalled while response path free");

  a_wake_implies_done: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.wake_lock_waiter) |-> (rsp.status == ST_DONE))
    else $error("lock wakeup reported without done status");

  a_cond_wake_implies_done: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.cond_wake_count != '0) |-> (rsp.status == ST_DONE))
    else $error("condition wakeups reported without done status");

  a_index_implies_done: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.new_index != '0) |-> (rsp.status == ST_DONE))
    else $error("new index reported on a failed command");

endmodule

>>> bench/lock_and_condition_table_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for lock_and_condition_table_core: lock and condition table commands.
// Depends on lact_pkg and the core; a local table model predicts every response word.
module lock_and_condition_table_core_tb;
  import lact_pkg::*;

  localparam int LOCKS          = LOCK_COUNT_DEF;
  localparam int CONDS          = COND_COUNT_DEF;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_OFF_LEN   = 200;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_REPORTS    = 100;
  localparam int RANDOM_ITEMS   = 300;
  // Command codes the block does not define
  localparam logic [3:0] CMD_UNUSED_FIRST = 4'd10;
  localparam logic [3:0] CMD_UNUSED_LAST  = 4'd15;

  logic      clk;
  logic      rst;
  logic      cmd_valid;
  logic      cmd_stall;
  cmd_word_t cmd;
  logic      rsp_valid;
  logic      rsp_stall;
  rsp_word_t rsp;

  // Table model, kept in step with accepted command words
  logic [LOCKS-1:0] lk_used;
  lock_mode_t       lk_mode    [LOCKS];
  logic [5:0]       lk_owner   [LOCKS];
  logic [15:0]      lk_nest    [LOCKS];
  logic [6:0]       lk_waiters [LOCKS];
  logic [CONDS-1:0] cv_used;
  logic [6:0]       cv_waiters [CONDS];

  rsp_word_t pending_rsp_q [$];
  rsp_word_t last_predicted;
  rsp_word_t oldest_rsp;
  int        error_count;
  int        send_idle_pct;
  int        rsp_stall_pct;
  int        hold_off_left;

  lock_and_condition_table_core dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (error_count < MAX_REPORTS)
      $display("%0t ns: %s mismatch, got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // One release level; ownership already checked. Returns the hand-off flag.
  function automatic logic release_level(input logic [4:0] li);
    if (lk_nest[li] > 16'd1) begin
      lk_nest[li] = lk_nest[li] - 16'd1;
      return 1'b0;
    end
    lk_nest[li]  = '0;
    lk_owner[li] = '0;
    if (lk_waiters[li] != '0) begin
      lk_mode[li] = MODE_RESERVED;
      return 1'b1;
    end
    lk_mode[li] = MODE_FREE;
    return 1'b0;
  endfunction

  // Applies one command word to the table model and returns its response word
  function automatic rsp_word_t predict_table(input cmd_word_t w);
    rsp_word_t  r;
    logic [4:0] li;
    logic [4:0] ci;
    logic       lock_live;
    logic       cond_live;
    logic       owns;
    li = w.lock_index;
    ci = w.cond_index;
    r.status           = ST_BUSY;
    r.new_index        = '0;
    r.wake_lock_waiter = 1'b0;
    r.cond_wake_count  = '0;
    lock_live = lk_used[li];
    cond_live = cv_used[ci];
    owns = lock_live && lk_mode[li] == MODE_HELD && lk_owner[li] == w.thread_id;
    case (w.command)
      CMD_LOCK_CREATE: begin
        r.status = ST_FULL;
        for (int i = 0; i < LOCKS; i++) begin
          if (!lk_used[i] && r.status == ST_FULL) begin
            lk_used[i]    = 1'b1;
            lk_mode[i]    = MODE_FREE;
            lk_owner[i]   = '0;
            lk_nest[i]    = '0;
            lk_waiters[i] = '0;
            r.status      = ST_DONE;
            r.new_index   = 5'(i);
          end
        end
      end
      CMD_LOCK_DESTROY: begin
        if (lock_live && lk_mode[li] == MODE_FREE && lk_waiters[li] == '0) begin
          lk_used[li] = 1'b0;
          r.status    = ST_DONE;
        end
      end
      CMD_ACQUIRE: begin
        if (lock_live) begin
          if (lk_mode[li] == MODE_FREE) begin
            lk_mode[li]  = MODE_HELD;
            lk_owner[li] = w.thread_id;
            lk_nest[li]  = 16'd1;
            r.status     = ST_DONE;
          end else if (owns) begin
            if (lk_nest[li] < NEST_MAX) lk_nest[li] = lk_nest[li] + 16'd1;
            r.status = ST_NESTED;
          end else begin
            if (lk_waiters[li] < WAIT_MAX) lk_waiters[li] = lk_waiters[li] + 7'd1;
            r.status = ST_WAIT;
          end
        end
      end
      CMD_RESUME: begin
        if (lock_live && lk_mode[li] == MODE_RESERVED) begin
          if (lk_waiters[li] != '0) lk_waiters[li] = lk_waiters[li] - 7'd1;
          lk_mode[li]  = MODE_HELD;
          lk_owner[li] = w.thread_id;
          lk_nest[li]  = 16'd1;
          r.status     = ST_DONE;
        end
      end
      CMD_RELEASE: begin
        if (lock_live) begin
          if (!owns) begin
            r.status = ST_NOTOWNER;
          end else begin
            r.wake_lock_waiter = release_level(li);
            r.status           = ST_DONE;
          end
        end
      end
      CMD_COND_CREATE: begin
        r.status = ST_FULL;
        for (int i = 0; i < CONDS; i++) begin
          if (!cv_used[i] && r.status == ST_FULL) begin
            cv_used[i]    = 1'b1;
            cv_waiters[i] = '0;
            r.status      = ST_DONE;
            r.new_index   = 5'(i);
          end
        end
      end
      CMD_COND_DESTROY: begin
        if (cond_live && cv_waiters[ci] == '0) begin
          cv_used[ci] = 1'b0;
          r.status    = ST_DONE;
        end
      end
      CMD_WAIT: begin
        if (cond_live && lock_live) begin
          if (!owns) begin
            r.status = ST_NOTOWNER;
          end else begin
            if (cv_waiters[ci] < WAIT_MAX) cv_waiters[ci] = cv_waiters[ci] + 7'd1;
            r.wake_lock_waiter = release_level(li);
            r.status           = ST_DONE;
          end
        end
      end
      CMD_SIGNAL: begin
        if (cond_live) begin
          if (cv_waiters[ci] != '0) begin
            cv_waiters[ci]    = cv_waiters[ci] - 7'd1;
            r.cond_wake_count = 7'd1;
          end
          r.status = ST_DONE;
        end
      end
      CMD_BROADCAST: begin
        if (cond_live) begin
          r.cond_wake_count = cv_waiters[ci];
          cv_waiters[ci]    = '0;
          r.status          = ST_DONE;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offers one word after a random gap; predicts it once it is taken
  task automatic send_word(input cmd_word_t w);
    logic [$bits(cmd_word_t)-1:0] idle_noise;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      idle_noise = $urandom;
      cmd_valid <= 1'b0;
      cmd       <= idle_noise;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= w;
    @(posedge clk);
    while (cmd_stall !== 1'b0) @(posedge clk);
    last_predicted = predict_table(w);
    pending_rsp_q.push_back(last_predicted);
  endtask

  task automatic issue(input cmd_code_t op, input logic [4:0] li, input logic [4:0] ci,
                       input logic [5:0] tid);
    cmd_word_t w;
    w.command    = op;
    w.lock_index = li;
    w.cond_index = ci;
    w.thread_id  = tid;
    send_word(w);
  endtask

  // Sender goes quiet until every expected response word is back
  task automatic drain();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending_rsp_q.size() != 0) @(posedge clk);
  endtask

  // Mostly a live entry, sometimes any entry
  function automatic logic [4:0] pick_entry(input logic [31:0] used);
    int         live_cnt;
    int         k;
    logic [4:0] pick;
    live_cnt = $countones(used);
    pick = 5'($urandom_range(31));
    if (live_cnt != 0 && $urandom_range(9) != 0) begin
      k = $urandom_range(live_cnt - 1);
      for (int i = 0; i < 32; i++) begin
        if (used[i]) begin
          if (k == 0) pick = 5'(i);
          k--;
        end
      end
    end
    return pick;
  endfunction

  // Well-formed traffic steered by the table model, with some noise words
  task automatic random_item();
    cmd_word_t                    w;
    logic [$bits(cmd_word_t)-1:0] noise;
    cmd_code_t                    op;
    logic [4:0]                   li;
    logic [4:0]                   ci;
    logic [5:0]                   tid;
    int unsigned                  dice;
    li  = pick_entry(lk_used);
    ci  = pick_entry(cv_used);
    tid = ($urandom_range(7) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(3));
    dice = $urandom_range(99);
    if (dice < 10) begin
      noise = $urandom;
      w = noise;
    end else begin
      if ($countones(lk_used) < 3) op = CMD_LOCK_CREATE;
      else if ($countones(cv_used) < 2) op = CMD_COND_CREATE;
      else if (lk_mode[li] == MODE_RESERVED && dice < 50) op = CMD_RESUME;
      else begin
        dice = $urandom_range(99);
        if (dice < 4) op = CMD_LOCK_CREATE;
        else if (dice < 7) op = CMD_LOCK_DESTROY;
        else if (dice < 27) op = CMD_ACQUIRE;
        else if (dice < 33) op = CMD_RESUME;
        else if (dice < 55) op = CMD_RELEASE;
        else if (dice < 58) op = CMD_COND_CREATE;
        else if (dice < 61) op = CMD_COND_DESTROY;
        else if (dice < 76) op = CMD_WAIT;
        else if (dice < 89) op = CMD_SIGNAL;
        else op = CMD_BROADCAST;
      end
      if ((op == CMD_RELEASE || op == CMD_WAIT) && lk_mode[li] == MODE_HELD &&
          $urandom_range(4) != 0)
        tid = lk_owner[li];
      w.command    = op;
      w.lock_index = li;
      w.cond_index = ci;
      w.thread_id  = tid;
    end
    send_word(w);
  endtask

  // Every command, bad entries, busy destroys, hand-off through the reserved mode
  task automatic test_directed_basics();
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    issue(CMD_ACQUIRE, 5'd0, 5'd0, 6'd0);
    issue(cmd_code_t'(CMD_UNUSED_LAST), 5'd31, 5'd31, 6'd63);
    issue(cmd_code_t'(CMD_UNUSED_FIRST), 5'd0, 5'd0, 6'd0);
    issue(CMD_SIGNAL, 5'd0, 5'd0, 6'd0);
    issue(CMD_LOCK_CREATE, 5'd31, 5'd31, 6'd0);
    issue(CMD_COND_CREATE, 5'd31, 5'd31, 6'd0);
    issue(CMD_ACQUIRE, 5'd0, 5'd0, 6'd63);
    issue(CMD_ACQUIRE, 5'd0, 5'd0, 6'd63);
    issue(CMD_ACQUIRE, 5'd0, 5'd0, 6'd0);
    issue(CMD_RELEASE, 5'd0, 5'd0, 6'd0);
    issue(CMD_LOCK_DESTROY, 5'd0, 5'd0, 6'd0);
    issue(CMD_WAIT, 5'd0, 5'd0, 6'd0);
    issue(CMD_WAIT, 5'd0, 5'd0, 6'd63);
    issue(CMD_COND_DESTROY, 5'd0, 5'd0, 6'd0);
    issue(CMD_RELEASE, 5'd0, 5'd0, 6'd63);
    issue(CMD_ACQUIRE, 5'd0, 5'd0, 6'd63);
    issue(CMD_RELEASE, 5'd0, 5'd0, 6'd63);
    issue(CMD_RESUME, 5'd0, 5'd0, 6'd0);
    issue(CMD_RESUME, 5'd0, 5'd0, 6'd0);
    issue(CMD_SIGNAL, 5'd0, 5'd0, 6'd0);
    issue(CMD_BROADCAST, 5'd0, 5'd0, 6'd0);
    issue(CMD_COND_DESTROY, 5'd0, 5'd0, 6'd0);
    issue(CMD_RELEASE, 5'd0, 5'd0, 6'd0);
    issue(CMD_RESUME, 5'd0, 5'd0, 6'd63);
    issue(CMD_RELEASE, 5'd0, 5'd0, 6'd63);
    issue(CMD_LOCK_DESTROY, 5'd0, 5'd0, 6'd0);
    issue(CMD_WAIT, 5'd0, 5'd0, 6'd63);
    drain();
  endtask

  // Fill both tables, free a middle entry, check it is reused, then empty them
  task automatic test_table_full();
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    do issue(CMD_LOCK_CREATE, 5'd0, 5'd0, 6'd0); while (last_predicted.status != ST_FULL);
    do issue(CMD_COND_CREATE, 5'd0, 5'd0, 6'd0); while (last_predicted.status != ST_FULL);
    issue(CMD_LOCK_DESTROY, 5'd13, 5'd0, 6'd0);
    issue(CMD_COND_DESTROY, 5'd0, 5'd22, 6'd0);
    issue(CMD_LOCK_CREATE, 5'd0, 5'd0, 6'd0);
    issue(CMD_COND_CREATE, 5'd0, 5'd0, 6'd0);
    for (int i = 0; i < 32; i++) begin
      issue(CMD_LOCK_DESTROY, 5'(i), 5'd0, 6'd0);
      issue(CMD_COND_DESTROY, 5'd0, 5'(i), 6'd0);
    end
    drain();
  endtask

  // Deep nesting, both waiter counts into saturation and back out
  task automatic test_counter_saturation();
    logic [4:0] lk;
    logic [4:0] cv;
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    issue(CMD_LOCK_CREATE, 5'd0, 5'd0, 6'd0);
    lk = last_predicted.new_index;
    issue(CMD_COND_CREATE, 5'd0, 5'd0, 6'd0);
    cv = last_predicted.new_index;
    repeat (140) issue(CMD_ACQUIRE, lk, cv, 6'd1);
    repeat (130) issue(CMD_ACQUIRE, lk, cv, 6'd2);
    repeat (130) issue(CMD_WAIT, lk, cv, 6'd1);
    issue(CMD_BROADCAST, lk, cv, 6'd1);
    issue(CMD_SIGNAL, lk, cv, 6'd1);
    // last of these hands the lock over
    repeat (140 - 130) issue(CMD_RELEASE, lk, cv, 6'd1);
    repeat (128) begin
      issue(CMD_RESUME, lk, cv, 6'd2);
      issue(CMD_RELEASE, lk, cv, 6'd2);
    end
    issue(CMD_LOCK_DESTROY, lk, cv, 6'd0);
    issue(CMD_COND_DESTROY, lk, cv, 6'd0);
    drain();
  endtask

  // Long receiver hold-off while the sender keeps offering words
  task automatic test_backpressure();
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    hold_off_left = HOLD_OFF_LEN;
    repeat (40) random_item();
    drain();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
    send_idle_pct = idle_pct;
    rsp_stall_pct = stall_pct;
    repeat (count) random_item();
    drain();
  endtask

  // Receiver stall: random, or held high through a hold-off
  always @(posedge clk) begin
    if (hold_off_left > 0) begin
      rsp_stall <= 1'b1;
      hold_off_left--;
    end else begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
    end
  end

  // Response checker: each accepted word against the oldest expectation
  always @(posedge clk) begin
    if (!rst) begin
      if ($isunknown({rsp_valid, cmd_stall}))
        report_mismatch("handshake unknown", 16'({rsp_valid, cmd_stall}), '0);
      if (rsp_valid && !rsp_stall) begin
        if (pending_rsp_q.size() == 0) begin
          report_mismatch("unexpected response word", rsp, '0);
        end else begin
          oldest_rsp = pending_rsp_q.pop_front();
          if (rsp.status !== oldest_rsp.status)
            report_mismatch("status", 16'(rsp.status), 16'(oldest_rsp.status));
          if (rsp.new_index !== oldest_rsp.new_index)
            report_mismatch("new_index", 16'(rsp.new_index), 16'(oldest_rsp.new_index));
          if (rsp.wake_lock_waiter !== oldest_rsp.wake_lock_waiter)
            report_mismatch("wake_lock_waiter", 16'(rsp.wake_lock_waiter),
                            16'(oldest_rsp.wake_lock_waiter));
          if (rsp.cond_wake_count !== oldest_rsp.cond_wake_count)
            report_mismatch("cond_wake_count", 16'(rsp.cond_wake_count),
                            16'(oldest_rsp.cond_wake_count));
        end
      end
    end
  end

  // Watchdog: too long without any word moving on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    cmd_valid     = 1'b0;
    cmd           = '0;
    rsp_stall     = 1'b0;
    error_count   = 0;
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    hold_off_left = 0;
    lk_used       = '0;
    cv_used       = '0;
    for (int i = 0; i < LOCKS; i++) begin
      lk_mode[i]    = MODE_FREE;
      lk_owner[i]   = '0;
      lk_nest[i]    = '0;
      lk_waiters[i] = '0;
    end
    for (int i = 0; i < CONDS; i++) cv_waiters[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_directed_basics();
    test_table_full();
    test_counter_saturation();
    test_backpressure();
    test_random_traffic(0, 0, RANDOM_ITEMS);
    test_random_traffic(82, 0, RANDOM_ITEMS);
    test_random_traffic(0, 82, RANDOM_ITEMS);
    test_random_traffic(21, 21, RANDOM_ITEMS);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

>>> files.f
design/lact_pkg.sv
design/lock_and_condition_table_core.sv
bench/lock_and_condition_table_core_tb.sv
